FILE: rtl/fsts_pkg.sv
`default_nettype none
package fsts_pkg;

	localparam int unsigned MAX_WORKERS_DEF = 4;
	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned NOMINAL_WEIGHT = 1024;
	localparam int unsigned VRUNTIME_STEP = 1;
	// quotient bits of NOMINAL_WEIGHT / weight
	localparam int unsigned DIV_BITS = 11;

	typedef enum logic [1:0] {
		KIND_SUBMIT  = 2'd0,
		KIND_DEQUEUE = 2'd1,
		KIND_REQUEUE = 2'd2,
		KIND_YIELD   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  worker;
		logic        any_worker;
		logic [7:0]  task_id;
		logic [15:0] task_weight;
		logic [63:0] task_vruntime;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_task_id;
		logic [63:0] out_vruntime;
		logic [15:0] out_weight;
		logic [1:0]  out_queue;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  task_id;
		logic [63:0] vruntime;
		logic [15:0] weight;
	} entry_t;

endpackage
`default_nettype wire

FILE: rtl/fair_share_task_scheduler_core.sv
`default_nettype none
// Fair-share task scheduler: one run queue per worker, held in a single-port-write,
// registered-read entry memory of MAX_WORKERS*QUEUE_DEPTH slots, ordered by
// virtual runtime with ties to the lower task id. One transaction is worked at a
// time and gives one response. After reset a clearing pass over all MAX_WORKERS*QUEUE_DEPTH
// slots runs before the first request is taken. Each request first brings the worker index
// below the active count by subtraction (at most three steps); dequeue then walks the steal
// ring past empty queues, and yield first runs a bit-serial divide of 1024 by a nonzero
// weight. The memory scan reads one slot per cycle; a dropped item on a full queue skips
// the scan, as does a dequeue that finds every active queue empty. After the response is
// loaded, which waits while an earlier response is still held, the block returns to idle
// and takes the next request. active_workers may be written any time the block is idle.
module fair_share_task_scheduler_core #(
	parameter int unsigned MAX_WORKERS = fsts_pkg::MAX_WORKERS_DEF,
	parameter int unsigned QUEUE_DEPTH = fsts_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [2:0]     cfg_data,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire fsts_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output fsts_pkg::rsp_t      rsp
);

	localparam int unsigned TOTAL = MAX_WORKERS * QUEUE_DEPTH;
	localparam int unsigned AW    = $clog2(TOTAL);
	localparam int unsigned QWI   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int unsigned CW0   = $clog2(MAX_WORKERS + 1);
	localparam int unsigned CW    = (CW0 > 3) ? CW0 : 3;
	localparam int unsigned SW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned NW    = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned TW    = $clog2(TOTAL + 1);

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_REDUCE = 9'b000000100,
		S_DIVIDE = 9'b000001000,
		S_PREP   = 9'b000010000,
		S_FIND   = 9'b000100000,
		S_SCAN   = 9'b001000000,
		S_WRITE  = 9'b010000000,
		S_RESP   = 9'b100000000
	} state_t;

	state_t state_q;

	// entry memory
	fsts_pkg::entry_t mem [TOTAL];
	fsts_pkg::entry_t mem_rd_q;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	fsts_pkg::entry_t mem_wd;
	logic [AW-1:0]    mem_ra;

	logic [2:0]          act_q;
	logic [CW-1:0]       n_act;
	logic [CW-1:0]       rr_q;
	logic [NW-1:0]       cnt_q  [MAX_WORKERS];
	logic [63:0]         qmin_q [MAX_WORKERS];
	logic [TW-1:0]       clr_q;

	fsts_pkg::req_t      req_q;
	logic [CW-1:0]       q_q;
	logic [CW-1:0]       tries_q;
	logic [16:0]         div_rem_q;
	logic [fsts_pkg::DIV_BITS-1:0] div_quo_q;
	logic [3:0]          div_i_q;
	logic [63:0]         vr_q;
	logic [15:0]         w_q;

	logic [NW-1:0]       scan_q;
	logic                scan_v_s1;
	logic [SW-1:0]       slot_s1;
	logic                found_q;
	logic [SW-1:0]       free_q;
	logic                best_v_q;
	logic [SW-1:0]       best_slot_q;
	fsts_pkg::entry_t    best_q;
	logic                sec_v_q;
	logic [63:0]         sec_vr_q;
	logic [7:0]          sec_task_q;

	fsts_pkg::rsp_t      res_q;
	fsts_pkg::rsp_t      rsp_q;
	logic                rsp_valid_q;

	logic [QWI-1:0]      qi;
	logic                is_deq;
	logic [CW-1:0]       q_next;
	logic [16:0]         div_try;
	logic [63:0]         delta;
	logic [63:0]         vr_sum;
	logic                beat_best;
	logic                beat_sec;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// active queue count, clamped to 1..MAX_WORKERS
	always_comb begin
		if (act_q == 3'd0) begin
			n_act = CW'(1);
		end else if (CW'(act_q) > CW'(MAX_WORKERS)) begin
			n_act = CW'(MAX_WORKERS);
		end else begin
			n_act = CW'(act_q);
		end
	end

	assign qi     = q_q[QWI-1:0];
	assign is_deq = (req_q.kind == fsts_pkg::KIND_DEQUEUE);
	assign q_next = (q_q + CW'(1) == n_act) ? '0 : q_q + CW'(1);

	// divider step: shift in next dividend bit (only bit 10 of 1024 is set)
	assign div_try = {div_rem_q[15:0], (div_i_q == 4'(fsts_pkg::DIV_BITS - 1))};

	// yield increment
	always_comb begin
		if (req_q.task_weight == 16'd0 || div_quo_q == '0) begin
			delta = 64'(fsts_pkg::VRUNTIME_STEP);
		end else begin
			delta = 64'(div_quo_q);
		end
		if (req_q.kind == fsts_pkg::KIND_YIELD) begin
			vr_sum = req_q.task_vruntime + delta;
		end else begin
			vr_sum = req_q.task_vruntime;
		end
	end

	// ordering of scanned entry against best and runner-up
	always_comb begin
		beat_best = !best_v_q || (mem_rd_q.vruntime < best_q.vruntime) ||
			(mem_rd_q.vruntime == best_q.vruntime && mem_rd_q.task_id < best_q.task_id);
		beat_sec = !sec_v_q || (mem_rd_q.vruntime < sec_vr_q) ||
			(mem_rd_q.vruntime == sec_vr_q && mem_rd_q.task_id < sec_task_q);
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_ra = AW'(AW'(qi) * AW'(QUEUE_DEPTH) + AW'(scan_q[SW-1:0]));
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q[AW-1:0];
		end else if (state_q == S_WRITE) begin
			mem_we = 1'b1;
			if (is_deq) begin
				mem_wa = AW'(AW'(qi) * AW'(QUEUE_DEPTH) + AW'(best_slot_q));
				mem_wd = '0;
			end else begin
				mem_wa = AW'(AW'(qi) * AW'(QUEUE_DEPTH) + AW'(free_q));
				mem_wd = '{valid: 1'b1, task_id: req_q.task_id, vruntime: vr_q,
					weight: w_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[mem_ra];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 3'd4;
		end else if (cfg_valid) begin
			act_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rr_q        <= '0;
			rsp_valid_q <= 1'b0;
			scan_v_s1   <= 1'b0;
			for (int i = 0; i < MAX_WORKERS; i++) begin
				cnt_q[i]  <= '0;
				qmin_q[i] <= '0;
			end
		end else begin
			// response taken; a reload in S_RESP keeps it valid
			if (rsp_valid_q && rsp_ready && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			scan_v_s1 <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + TW'(1);
					if (clr_q == TW'(TOTAL - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						if (req.kind == fsts_pkg::KIND_SUBMIT && req.any_worker) begin
							q_q <= rr_q;
						end else begin
							q_q <= CW'(req.worker);
						end
						state_q <= S_REDUCE;
					end
				end
				// bring the queue number below the active count
				S_REDUCE: begin
					if (q_q >= n_act) begin
						q_q <= q_q - n_act;
					end else begin
						if (req_q.kind == fsts_pkg::KIND_SUBMIT && req_q.any_worker) begin
							rr_q <= q_next;
						end
						div_rem_q <= '0;
						div_quo_q <= '0;
						div_i_q   <= 4'(fsts_pkg::DIV_BITS - 1);
						tries_q   <= '0;
						if (is_deq) begin
							state_q <= S_FIND;
						end else if (req_q.kind == fsts_pkg::KIND_YIELD &&
							req_q.task_weight != 16'd0) begin
							state_q <= S_DIVIDE;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				// restoring divide, one quotient bit a cycle
				S_DIVIDE: begin
					if (div_try >= {1'b0, req_q.task_weight}) begin
						div_rem_q <= div_try - {1'b0, req_q.task_weight};
						div_quo_q <= {div_quo_q[fsts_pkg::DIV_BITS-2:0], 1'b1};
					end else begin
						div_rem_q <= div_try;
						div_quo_q <= {div_quo_q[fsts_pkg::DIV_BITS-2:0], 1'b0};
					end
					div_i_q <= div_i_q - 4'd1;
					if (div_i_q == 4'd0) begin
						state_q <= S_PREP;
					end
				end
				// key and weight to store; full queue drops the item
				S_PREP: begin
					logic [63:0] v;
					logic [15:0] w;
					if (req_q.kind == fsts_pkg::KIND_SUBMIT) begin
						v = qmin_q[qi];
						w = (req_q.task_weight == 16'd0) ?
							16'(fsts_pkg::NOMINAL_WEIGHT) : req_q.task_weight;
					end else begin
						v = (vr_sum < qmin_q[qi]) ? qmin_q[qi] : vr_sum;
						w = req_q.task_weight;
					end
					vr_q <= v;
					w_q  <= w;
					res_q <= '{status: fsts_pkg::ST_FULL, out_task_id: req_q.task_id,
						out_vruntime: v, out_weight: w, out_queue: q_q[1:0]};
					scan_q  <= '0;
					found_q <= 1'b0;
					if (cnt_q[qi] == NW'(QUEUE_DEPTH)) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_SCAN;
					end
				end
				// steal ring: first non-empty queue from own
				S_FIND: begin
					scan_q   <= '0;
					best_v_q <= 1'b0;
					sec_v_q  <= 1'b0;
					if (cnt_q[qi] != '0) begin
						state_q <= S_SCAN;
					end else if (tries_q + CW'(1) >= n_act) begin
						res_q   <= '{status: fsts_pkg::ST_EMPTY, default: '0};
						state_q <= S_RESP;
					end else begin
						q_q     <= q_next;
						tries_q <= tries_q + CW'(1);
					end
				end
				// one slot read per cycle, result registered and used in the next cycle
				S_SCAN: begin
					if (scan_q < NW'(QUEUE_DEPTH)) begin
						scan_q    <= scan_q + NW'(1);
						scan_v_s1 <= 1'b1;
						slot_s1   <= scan_q[SW-1:0];
					end
					if (scan_v_s1) begin
						if (is_deq) begin
							if (mem_rd_q.valid) begin
								if (beat_best) begin
									best_v_q    <= 1'b1;
									best_q      <= mem_rd_q;
									best_slot_q <= slot_s1;
									sec_v_q     <= best_v_q;
									sec_vr_q    <= best_q.vruntime;
									sec_task_q  <= best_q.task_id;
								end else if (beat_sec) begin
									sec_v_q    <= 1'b1;
									sec_vr_q   <= mem_rd_q.vruntime;
									sec_task_q <= mem_rd_q.task_id;
								end
							end
						end else if (!mem_rd_q.valid && !found_q) begin
							found_q <= 1'b1;
							free_q  <= slot_s1;
						end
						if (slot_s1 == SW'(QUEUE_DEPTH - 1)) begin
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					if (is_deq) begin
						cnt_q[qi]  <= cnt_q[qi] - NW'(1);
						qmin_q[qi] <= sec_v_q ? sec_vr_q : best_q.vruntime;
						res_q <= '{status: fsts_pkg::ST_DONE, out_task_id: best_q.task_id,
							out_vruntime: best_q.vruntime, out_weight: best_q.weight,
							out_queue: q_q[1:0]};
					end else begin
						cnt_q[qi]    <= cnt_q[qi] + NW'(1);
						res_q.status <= fsts_pkg::ST_DONE;
					end
					state_q <= S_RESP;
				end
				// hand result to the output register once it is free
				S_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
